// ----- src/sfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find/replace unit
// Holds the byte and register widths, the configuration register indexes,
// the flags that travel with each output burst and the ASCII upcase helper.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int LEN_W      = 4;
    localparam int MATCH_W    = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 4'd0,
        REG_PATTERN_LENGTH     = 4'd1,
        REG_REPLACEMENT_BYTES  = 4'd2,
        REG_REPLACEMENT_LENGTH = 4'd3
    } cfg_index_t;

    // Flags that accompany one burst of output bytes.
    typedef struct packed {
        logic last;    // the final byte of the burst closes the text
        logic marker;  // the burst is the single empty end marker
    } burst_flags_t;

    // ASCII upcase of the letters a to z only.
    function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- src/stream_find_replace_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_unit: streaming case-insensitive find and replace
// Text bytes come in one transaction at a time; bytes matching the pattern
// are held until the match completes (replacement emitted), or fails or the
// text ends (held bytes and the current byte pass through unchanged).
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_in_byte, s_in_last
//   m_       out        m_valid/m_ready    m_out_byte, m_out_valid, m_out_last
//   cfg_     in         cfg_wr_en          cfg_index, cfg_data
//
// An input byte is registered, then matched and turned into a burst of up to
// max(MAX_PATTERN, MAX_REPLACEMENT) results in the burst register, which
// hands the results out one at a time. The unit takes one byte per cycle
// while each byte yields at most one result and the receiver takes every
// result, and stalls input while a longer burst drains.
// Reset clears the match state, the output count and the configuration
// registers to zero; the data registers are left as they are.
// ----------------------------------------------------------------------------
module stream_find_replace_unit import sfr_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [BYTE_W-1:0]       s_in_byte,
    input  logic                    s_in_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BYTE_W-1:0]       m_out_byte,
    output logic                    m_out_valid,
    output logic                    m_out_last,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int BURST_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                 MAX_PATTERN : MAX_REPLACEMENT;
    localparam int CNT_W = $clog2(BURST_DEPTH + 1);

    logic [CFG_DATA_W-1:0]  pattern_bytes_reg;
    logic [LEN_W-1:0]       pattern_length_reg;
    logic [CFG_DATA_W-1:0]  replacement_bytes_reg;
    logic [LEN_W-1:0]       replacement_length_reg;

    logic                               burst_valid;
    logic                               burst_ready;
    logic [BURST_DEPTH-1:0][BYTE_W-1:0] burst_bytes;
    logic [CNT_W-1:0]                   burst_count;
    burst_flags_t                       burst_flags;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= '0;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                REG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Matching and burst building.
    sfr_match #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .BURST_DEPTH     (BURST_DEPTH),
        .CNT_W           (CNT_W)
    ) u_match (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_in_byte          (s_in_byte),
        .s_in_last          (s_in_last),
        .pattern_bytes      (pattern_bytes_reg),
        .pattern_length     (pattern_length_reg),
        .replacement_bytes  (replacement_bytes_reg),
        .replacement_length (replacement_length_reg),
        .burst_valid        (burst_valid),
        .burst_ready        (burst_ready),
        .burst_bytes        (burst_bytes),
        .burst_count        (burst_count),
        .burst_flags        (burst_flags)
    );

    // Output serialisation.
    sfr_serial #(
        .BURST_DEPTH (BURST_DEPTH),
        .CNT_W       (CNT_W)
    ) u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst_bytes (burst_bytes),
        .burst_count (burst_count),
        .burst_flags (burst_flags),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last)
    );

endmodule

// ----- src/sfr_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_match: input register, match state and burst builder
// Registers each incoming byte, compares it against the pattern byte at the
// current match position and builds the burst of bytes that it releases.
// ----------------------------------------------------------------------------
module sfr_match import sfr_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int BURST_DEPTH = 8,
    parameter int CNT_W = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [BYTE_W-1:0]                   s_in_byte,
    input  logic                                s_in_last,
    input  logic [CFG_DATA_W-1:0]               pattern_bytes,
    input  logic [LEN_W-1:0]                    pattern_length,
    input  logic [CFG_DATA_W-1:0]               replacement_bytes,
    input  logic [LEN_W-1:0]                    replacement_length,
    output logic                                burst_valid,
    input  logic                                burst_ready,
    output logic [BURST_DEPTH-1:0][BYTE_W-1:0]  burst_bytes,
    output logic [CNT_W-1:0]                    burst_count,
    output burst_flags_t                        burst_flags
);

    logic                                 valid_reg;
    logic [BYTE_W-1:0]                    byte_reg;
    logic                                 last_reg;
    logic [MATCH_W-1:0]                   mc_reg;
    logic [MATCH_W-1:0]                   mc_next;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0]   held_reg;

    logic [LEN_W-1:0]   plen_eff;
    logic [LEN_W-1:0]   rlen_eff;
    logic [LEN_W-1:0]   mc_inc;
    logic [BYTE_W-1:0]  pat_byte;
    logic               match;
    logic               full;
    logic               advance;

    // Lengths beyond the storage are treated as the maximum.
    assign plen_eff = (pattern_length > LEN_W'(MAX_PATTERN)) ?
                      LEN_W'(MAX_PATTERN) : pattern_length;
    assign rlen_eff = (replacement_length > LEN_W'(MAX_REPLACEMENT)) ?
                      LEN_W'(MAX_REPLACEMENT) : replacement_length;

    // Case-insensitive compare against the pattern byte at the match position.
    assign pat_byte = pattern_bytes[{mc_reg, 3'b000} +: BYTE_W];
    assign mc_inc   = {1'b0, mc_reg} + LEN_W'(1);
    assign match    = ({1'b0, mc_reg} < plen_eff) &&
                      (upcase(byte_reg) == upcase(pat_byte));
    assign full     = match && (mc_inc == plen_eff);

    // Build the burst: replacement on a full match, otherwise held bytes
    // followed by the current byte when a flush is due.
    always_comb begin
        burst_bytes = '0;
        burst_count = '0;
        burst_flags.last   = last_reg;
        burst_flags.marker = 1'b0;
        mc_next = '0;
        if (full) begin
            for (int i = 0; i < MAX_REPLACEMENT; i++) begin
                burst_bytes[i] = replacement_bytes[i*BYTE_W +: BYTE_W];
            end
            burst_count = CNT_W'(rlen_eff);
        end else if (match && !last_reg) begin
            mc_next = mc_inc[MATCH_W-1:0];
        end else begin
            for (int i = 0; i < BURST_DEPTH; i++) begin
                burst_bytes[i] = byte_reg;
            end
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (i < int'(mc_reg)) begin
                    burst_bytes[i] = held_reg[i];
                end
            end
            burst_count = CNT_W'(mc_inc);
        end
        // The last byte always yields at least the empty end marker.
        if (last_reg && burst_count == '0) begin
            burst_bytes        = '0;
            burst_count        = CNT_W'(1);
            burst_flags.marker = 1'b1;
        end
    end

    // Handshake: the registered byte moves on once its burst is taken, or when it yields no burst.
    assign burst_valid = valid_reg && (burst_count != '0);
    assign advance     = valid_reg && ((burst_count == '0) || burst_ready);
    assign s_ready     = !valid_reg || advance;

    // Input register and match state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mc_reg    <= '0;
        end else begin
            if (s_ready) begin
                valid_reg <= s_valid;
            end
            if (advance) begin
                mc_reg <= mc_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_in_byte;
            last_reg <= s_in_last;
        end
        if (advance && match) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (int'(mc_reg) == i) begin
                    held_reg[i] <= byte_reg;
                end
            end
        end
    end

    // The match position never reaches the pattern storage depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(mc_reg) < MAX_PATTERN)
        else $error("sfr_match: match position out of range");

    // A byte that waits for the serialiser leaves the match state alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !advance) |=> $stable(mc_reg))
        else $error("sfr_match: match state moved while stalled");

endmodule

// ----- src/sfr_serial.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_serial: burst register and output serialiser
// Holds one burst of up to BURST_DEPTH bytes, hands them out one transaction
// per cycle while m_ready is high, loading the next burst when empty or as the last byte leaves.
// ----------------------------------------------------------------------------
module sfr_serial import sfr_pkg::*; #(
    parameter int BURST_DEPTH = 8,
    parameter int CNT_W = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                burst_valid,
    output logic                                burst_ready,
    input  logic [BURST_DEPTH-1:0][BYTE_W-1:0]  burst_bytes,
    input  logic [CNT_W-1:0]                    burst_count,
    input  burst_flags_t                        burst_flags,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [BYTE_W-1:0]                   m_out_byte,
    output logic                                m_out_valid,
    output logic                                m_out_last
);

    logic [BURST_DEPTH-1:0][BYTE_W-1:0]  bytes_reg;
    logic [CNT_W-1:0]                    rem_reg;
    burst_flags_t                        flags_reg;
    logic                                load;
    logic                                pop;

    // A new burst enters when the register is empty or its final byte leaves.
    assign pop         = m_valid && m_ready;
    assign burst_ready = (rem_reg == '0) || ((rem_reg == CNT_W'(1)) && m_ready);
    assign load        = burst_valid && burst_ready;

    assign m_valid     = (rem_reg != '0);
    assign m_out_byte  = bytes_reg[0];
    assign m_out_valid = !flags_reg.marker;
    assign m_out_last  = flags_reg.last && (rem_reg == CNT_W'(1));

    // Remaining count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (load) begin
            rem_reg <= burst_count;
        end else if (pop) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    // Burst bytes shift down by one on every transaction.
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst_bytes;
            flags_reg <= burst_flags;
        end else if (pop) begin
            for (int i = 0; i < BURST_DEPTH - 1; i++) begin
                bytes_reg[i] <= bytes_reg[i+1];
            end
        end
    end

    // The remaining count never exceeds the burst storage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(rem_reg) <= BURST_DEPTH)
        else $error("sfr_serial: remaining count out of range");

    // The end marker is always a burst of exactly one result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && flags_reg.marker) |-> (rem_reg == CNT_W'(1) && flags_reg.last))
        else $error("sfr_serial: end marker not alone at end of text");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stream_find_replace_unit
// Sends text through the unit while random stalls hit both channels, and
// works out the expected output of every transaction with its own
// find/replace tracker. A short directed run covers case folding, the longest
// patterns, empty replacements, the end-of-text flush and length changes in
// the middle of a match. Random phases with varied settings follow.
// ----------------------------------------------------------------------------
module testbench;
    import sfr_pkg::*;

    localparam int PATTERN_MAX     = 8;
    localparam int REPLACE_MAX     = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 100;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 33;
    localparam int FIRST_UNUSED_INDEX = REG_REPLACEMENT_LENGTH + 1;
    localparam int LAST_UNUSED_INDEX  = (1 << CFG_IDX_W) - 1;

    // One output transaction as the bench expects to see it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
    } text_result_t;

    // Receiver stall patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_in_byte = '0;
    logic                  s_in_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BYTE_W-1:0]     m_out_byte;
    logic                  m_out_valid;
    logic                  m_out_last;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the unit's registers and match state.
    logic [CFG_DATA_W-1:0] search_bytes = '0;
    logic [LEN_W-1:0]      search_len = '0;
    logic [CFG_DATA_W-1:0] subst_bytes = '0;
    logic [LEN_W-1:0]      subst_len = '0;
    int                    match_depth = 0;
    logic [BYTE_W-1:0]     held_text [PATTERN_MAX];

    text_result_t pending_text [$];
    int           err_count = 0;
    int           burst_left = 0;
    bit           steady_send = 1'b0;
    int           hold_request = 0;

    stream_find_replace_unit #(
        .MAX_PATTERN     (PATTERN_MAX),
        .MAX_REPLACEMENT (REPLACE_MAX)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // ASCII upcase, letters only.
    function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
        if (c >= "a" && c <= "z") begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // Gives a letter a random case; other bytes are left alone.
    function automatic logic [BYTE_W-1:0] vary_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] up;
        up = to_upper(c);
        if (up >= "A" && up <= "Z" && $urandom_range(0, 1) == 1) begin
            return up | 8'h20;
        end
        return (up >= "A" && up <= "Z") ? up : c;
    endfunction

    // A byte from a narrow alphabet, so that partial matches are common.
    function automatic logic [BYTE_W-1:0] alphabet_byte();
        return vary_case(8'("A" + $urandom_range(0, 2)));
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        return ($urandom_range(0, 1) == 1) ? alphabet_byte() : 8'($urandom_range(0, 255));
    endfunction

    function automatic bit rand_last();
        return $urandom_range(0, 24) == 0;
    endfunction

    // Packs a short string into a register word, first character lowest.
    function automatic logic [CFG_DATA_W-1:0] pack_text(input string txt);
        logic [CFG_DATA_W-1:0] word;
        word = '0;
        for (int i = 0; i < txt.len() && i < PATTERN_MAX; i++) begin
            word[i*8 +: 8] = txt[i];
        end
        return word;
    endfunction

    // Works out the output transactions caused by one input byte and queues them.
    task automatic predict_text(input logic [BYTE_W-1:0] b, input logic last);
        int           plen;
        int           rlen;
        logic         hit;
        text_result_t burst [$];
        plen = (search_len > PATTERN_MAX) ? PATTERN_MAX : int'(search_len);
        rlen = (subst_len > REPLACE_MAX) ? REPLACE_MAX : int'(subst_len);
        hit = plen != 0 && match_depth < plen &&
              to_upper(b) == to_upper(search_bytes[match_depth*8 +: 8]);
        if (hit) begin
            held_text[match_depth] = b;
            match_depth++;
            if (match_depth == plen) begin
                for (int i = 0; i < rlen; i++) begin
                    burst.push_back('{subst_bytes[i*8 +: 8], 1'b1, 1'b0});
                end
                match_depth = 0;
            end else if (last) begin
                for (int i = 0; i < match_depth; i++) begin
                    burst.push_back('{held_text[i], 1'b1, 1'b0});
                end
                match_depth = 0;
            end
        end else begin
            // The held bytes flush ahead of the byte that broke the match.
            for (int i = 0; i < match_depth && i < PATTERN_MAX - 1; i++) begin
                burst.push_back('{held_text[i], 1'b1, 1'b0});
            end
            burst.push_back('{b, 1'b1, 1'b0});
            match_depth = 0;
        end
        if (last) begin
            if (burst.size() == 0) begin
                burst.push_back('{8'h00, 1'b0, 1'b0});
            end
            burst[burst.size()-1].last = 1'b1;
        end
        foreach (burst[i]) begin
            pending_text.push_back(burst[i]);
        end
    endtask

    // Offers one byte, waits for its transaction, then perhaps idles.
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        @(negedge aclk);
        s_valid   = 1'b1;
        s_in_byte = b;
        s_in_last = last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_text(b, last);
        if (!steady_send) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 5);
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(10, 30);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_string(input string txt, input bit last_at_end);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], last_at_end && i == txt.len() - 1);
        end
    endtask

    // Lets every expected transaction arrive, then gives held bytes time to settle.
    task automatic wait_results_done();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (pending_text.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        case (idx)
            REG_PATTERN_BYTES:      search_bytes = value;
            REG_PATTERN_LENGTH:     search_len   = value[LEN_W-1:0];
            REG_REPLACEMENT_BYTES:  subst_bytes  = value;
            REG_REPLACEMENT_LENGTH: subst_len    = value[LEN_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Writes all four registers once the unit is idle; length words carry
    // random upper bits, which the unit must ignore.
    task automatic apply_config(input logic [CFG_DATA_W-1:0] pat,
                                input logic [LEN_W-1:0] plen,
                                input logic [CFG_DATA_W-1:0] rep,
                                input logic [LEN_W-1:0] rlen);
        logic [CFG_DATA_W-1:0] junk;
        wait_results_done();
        junk = {$urandom, $urandom};
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, {junk[CFG_DATA_W-1:LEN_W], plen});
        junk = {$urandom, $urandom};
        write_reg(REG_REPLACEMENT_BYTES, rep);
        write_reg(REG_REPLACEMENT_LENGTH, {junk[CFG_DATA_W-1:LEN_W], rlen});
    endtask

    // With the reset settings everything passes straight through.
    task automatic test_passthrough();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    // '@' and '`' differ only in bit 5 but are not letters, so they must not fold.
    task automatic test_case_folding();
        apply_config(pack_text("@"), 4'd1, pack_text("#"), 4'd1);
        send_string("`@", 1'b1);
    endtask

    // Matching, a broken match whose current byte is not retested, the flush
    // at the end of text and the empty end marker.
    task automatic test_match_and_flush();
        apply_config(pack_text("ab"), 4'd2, pack_text("XY"), 4'd2);
        send_string("xAB", 1'b0);
        send_string("aa", 1'b0);
        send_string("a", 1'b1);
        apply_config(pack_text("ab"), 4'd2, pack_text("XY"), 4'd0);
        send_string("aB", 1'b1);
    endtask

    // Lengths above the maximum are clamped to eight bytes.
    task automatic test_long_pattern();
        apply_config(pack_text("ABCDEFGH"), 4'd15, {$urandom, $urandom}, 4'd15);
        send_string("abcdefgh", 1'b0);
    endtask

    // Shortening the pattern under a partial match turns the next byte into
    // a mismatch; a new replacement written mid-match is used at once.
    task automatic test_length_lowered();
        apply_config(pack_text("abcde"), 4'd5, pack_text("R"), 4'd1);
        send_string("abc", 1'b0);
        wait_results_done();
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        send_string("d", 1'b0);
        send_string("a", 1'b0);
        wait_results_done();
        write_reg(REG_REPLACEMENT_BYTES, pack_text("Q"));
        send_string("b", 1'b0);
    endtask

    // Writes to indexes beyond the register map must change nothing.
    task automatic test_unused_index();
        wait_results_done();
        for (int i = FIRST_UNUSED_INDEX; i <= LAST_UNUSED_INDEX; i++) begin
            write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        end
        write_reg(CFG_IDX_W'(LAST_UNUSED_INDEX), '1);
        send_string("aB", 1'b0);
    endtask

    // The receiver holds off while full matches keep arriving, so the unit
    // fills up and stalls its input; then the sender waits for everything.
    task automatic test_backpressure();
        apply_config(pack_text("ab"), 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        @(posedge aclk);
        hold_request = HOLD_CYCLES;
        steady_send = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_string("Ab", 1'b0);
        end
        steady_send = 1'b0;
        wait_results_done();
    endtask

    // Random text, mostly whole or broken occurrences of the pattern.
    task automatic test_random_text();
        int                    sent;
        int                    kind;
        int                    plen;
        int                    cut;
        logic [CFG_DATA_W-1:0] pat;
        logic [LEN_W-1:0]      plen_cfg;
        logic [LEN_W-1:0]      rlen_cfg;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin plen_cfg = 4'd8;  rlen_cfg = LEN_W'($urandom_range(0, 8)); end
                1: begin plen_cfg = 4'd1;  rlen_cfg = 4'd0; end
                2: begin plen_cfg = 4'd0;  rlen_cfg = 4'd15; end
                3: begin plen_cfg = 4'd15; rlen_cfg = 4'd8; end
                default: begin
                    plen_cfg = LEN_W'($urandom_range(2, 7));
                    rlen_cfg = LEN_W'($urandom_range(1, 15));
                end
            endcase
            for (int k = 0; k < PATTERN_MAX; k++) begin
                pat[k*8 +: 8] = ($urandom_range(0, 9) < 8) ? alphabet_byte()
                                                           : 8'($urandom_range(0, 255));
            end
            apply_config(pat, plen_cfg, {$urandom, $urandom}, rlen_cfg);
            plen = (plen_cfg > PATTERN_MAX) ? PATTERN_MAX : int'(plen_cfg);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 99);
                if (plen > 0 && kind < 55) begin
                    for (int k = 0; k < plen; k++) begin
                        send_item(vary_case(pat[k*8 +: 8]), rand_last());
                    end
                    sent += plen;
                end else if (plen > 1 && kind < 80) begin
                    cut = $urandom_range(1, plen - 1);
                    for (int k = 0; k < cut; k++) begin
                        send_item(vary_case(pat[k*8 +: 8]), rand_last());
                    end
                    send_item(noise_byte(), rand_last());
                    sent += cut + 1;
                end else begin
                    send_item(noise_byte(), rand_last());
                    sent++;
                end
            end
        end
    endtask

    // Receiver stalls: switches among patterns, with a long hold on request.
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        mode = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_ALWAYS:   m_ready = 1'b1;
                    RX_RANDOM:   m_ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_ready = (tick % 3 == 0);
                    default:     m_ready = 1'b1;
                endcase
            end
        end
    end

    // Compares each output transaction with the oldest expectation.
    initial begin
        text_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_text.size() == 0) begin
                    $error("unexpected output: out_byte %0h out_valid %0b out_last %0b",
                           m_out_byte, m_out_valid, m_out_last);
                    err_count++;
                end else begin
                    want = pending_text.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, m_out_byte);
                        err_count++;
                    end
                    if (m_out_valid !== want.valid) begin
                        $error("out_valid: expected %0b, got %0b", want.valid, m_out_valid);
                        err_count++;
                    end
                    if (m_out_last !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, m_out_last);
                        err_count++;
                    end
                end
            end
        end
    end

    // Ends the run if nothing moves on any port for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Reset, then each test in turn.
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_passthrough();
        test_case_folding();
        test_match_and_flush();
        test_long_pattern();
        test_length_lowered();
        test_unused_index();
        test_backpressure();
        test_random_text();

        wait_results_done();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/sfr_pkg.sv
src/sfr_match.sv
src/sfr_serial.sv
src/stream_find_replace_unit.sv
test/testbench.sv
